/* rtl/core/nsgs_pkg.sv */
// ----------------------------------------------------------------------------
// nsgs_pkg
// Shared types and constants for the nearest smaller/greater stack block.
// ----------------------------------------------------------------------------
package nsgs_pkg;

   // register index of the control register, taken from paddr bit 2
   localparam logic CSR_IDX_SEEK_GREATER = 1'b0;

   typedef struct packed {
      logic accept;   // capture the incoming beat
      logic pop;      // drop the cached top, fetch the next one
      logic load;     // move fetched entry into the top register
      logic finish;   // emit result and push the element
   } nsgs_cmd_type;

   typedef struct packed {
      logic empty;    // stack holds no entries
      logic keep;     // top satisfies the strict comparison
      logic out_free; // result register can take a new beat
   } nsgs_status_type;

endpackage

/* rtl/core/nsgs_ctrl.sv */
// ----------------------------------------------------------------------------
// nsgs_ctrl
// Sequencer: accepts a beat, pops failing entries through the compare and load
// states, then hands the result to the output register and pushes the element.
// ----------------------------------------------------------------------------
module nsgs_ctrl
   import nsgs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  nsgs_status_type status,
   output nsgs_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (!status.empty && !status.keep) begin
               cmd.pop  = 1'b1;
               state_in = ST_LOAD;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_COMPARE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/nsgs_dpath.sv */
// ----------------------------------------------------------------------------
// nsgs_dpath
// Stack storage with a cached top entry, signed compare, stack count and
// the result register.
// ----------------------------------------------------------------------------
module nsgs_dpath
   import nsgs_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nsgs_cmd_type           cmd,
   output nsgs_status_type        status,
   input  logic                   seek_greater,
   input  logic [VALUE_WIDTH-1:0] element_value,
   input  logic                   last_of_array,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] nearest_value,
   output logic                   found,
   output logic                   stack_overflow,
   output logic                   last_result
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];

   logic [VALUE_WIDTH-1:0] item_val_ff;
   logic                   item_last_ff;
   logic [VALUE_WIDTH-1:0] top_ff;
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [VALUE_WIDTH-1:0] nearest_ff;
   logic                   found_ff;
   logic                   ovf_ff;
   logic                   last_ff;

   logic [CW-1:0] rd_count;
   logic [CW-1:0] wr_count;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          full;
   logic          mem_we;

   assign rd_count = count_ff - CW'(2);
   assign wr_count = count_ff - CW'(1);
   assign rd_addr  = rd_count[AW-1:0];
   assign wr_addr  = wr_count[AW-1:0];
   assign full     = (count_ff == CW'(STACK_DEPTH));
   assign mem_we   = cmd.finish && !full && (count_ff != '0);

   assign status.empty    = (count_ff == '0);
   assign status.keep     = seek_greater ? ($signed(top_ff) > $signed(item_val_ff))
                                         : ($signed(top_ff) < $signed(item_val_ff));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // entries below the cached top live in memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= top_ff;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.finish) begin
         if (item_last_ff) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_val_ff  <= element_value;
         item_last_ff <= last_of_array;
      end
      if (cmd.load) begin
         top_ff <= rdata_ff;
      end else if (cmd.finish && !full) begin
         top_ff <= item_val_ff;
      end
      if (cmd.finish) begin
         nearest_ff <= status.empty ? '0 : top_ff;
         found_ff   <= !status.empty;
         ovf_ff     <= full;
         last_ff    <= item_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign nearest_value  = nearest_ff;
   assign found          = found_ff;
   assign stack_overflow = ovf_ff;
   assign last_result    = last_ff;

endmodule

/* rtl/core/nearest_smaller_greater_stack.sv */
// ----------------------------------------------------------------------------
// nearest_smaller_greater_stack
// Nearest earlier strictly smaller or strictly greater element per beat.
//
// Input beats on req_* carry one signed element in tdata and the end-of-array
// mark in tlast. Each input beat yields exactly one result beat on rsp_*:
// tdata holds the nearest qualifying earlier element (zero when none),
// tuser bit 0 is found, bit 1 is stack overflow, tlast echoes the mark.
// The csr register at address 0, bit 0, selects greater (1) or smaller (0);
// write it only while the block is idle.
// Sequence: a beat is taken in the idle state, then the compare state runs,
// and every stack entry popped passes through the compare and load states
// (one memory read, one load into the cached top register). Amortized,
// each element is popped at most once.
// A held result waits in the output register while the next beat is taken;
// the block stalls at the end of compare only if that register is still
// full. Synchronous reset empties the stack and the output register; the
// stack memory needs no clearing.
// ----------------------------------------------------------------------------
module nearest_smaller_greater_stack
   import nsgs_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32,
   parameter int DATA_WIDTH  = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,   // element_value
   input  logic                  req_tlast,   // last_of_array
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0] rsp_tdata,   // nearest_value
   output logic [1:0]            rsp_tuser,   // found, stack_overflow
   output logic                  rsp_tlast,   // last_result
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   nsgs_cmd_type    cmd;
   nsgs_status_type status;

   logic                   seek_greater_ff;
   logic                   seek_greater_in;
   logic [VALUE_WIDTH-1:0] nearest_value;
   logic                   found;
   logic                   stack_overflow;

   assign csr_pready = 1'b1;

   always_comb begin
      seek_greater_in = seek_greater_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == CSR_IDX_SEEK_GREATER) begin
         seek_greater_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seek_greater_ff <= 1'b0;
      end else begin
         seek_greater_ff <= seek_greater_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_SEEK_GREATER) ? {31'b0, seek_greater_ff}
                                                               : 32'b0;

   nsgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nsgs_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .seek_greater   (seek_greater_ff),
      .element_value  (req_tdata[VALUE_WIDTH-1:0]),
      .last_of_array  (req_tlast),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .nearest_value  (nearest_value),
      .found          (found),
      .stack_overflow (stack_overflow),
      .last_result    (rsp_tlast)
   );

   assign rsp_tdata = DATA_WIDTH'(nearest_value);
   assign rsp_tuser = {stack_overflow, found};

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_smaller_greater_stack. A queue of array
// elements feeds a clocked stream driver; every accepted element is run
// through a local monotonic-stack predictor and the expected result is
// queued. A clocked monitor compares each result beat field by field. Runs
// cover both search directions, equal values, extremes, stack overflow and
// random arrays, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   import nsgs_pkg::*;

   localparam int VALUE_W = 32;
   localparam int STACK_N = 1024;
   localparam int LONG_HOLD = 300;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [2:0] SEEK_GREATER_ADDR = {CSR_IDX_SEEK_GREATER, 2'b00};
   localparam logic [2:0] SPARE_ADDR = 3'b100;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } array_elem_type;

   typedef struct packed {
      logic [VALUE_W-1:0] nearest;
      logic               found;
      logic               overflow;
      logic               last;
   } nearest_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   wire                req_tready;
   logic [VALUE_W-1:0] req_tdata = '0;   // element_value
   logic               req_tlast = 1'b0; // last_of_array
   wire                rsp_tvalid;
   logic               rsp_tready = 1'b0;
   wire [VALUE_W-1:0]  rsp_tdata;        // nearest_value
   wire [1:0]          rsp_tuser;        // found, stack_overflow
   wire                rsp_tlast;        // last_result
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   wire [31:0]         csr_prdata;
   wire                csr_pready;

   array_elem_type            elem_queue[$];
   nearest_result_type        nearest_due[$];
   logic signed [VALUE_W-1:0] prior_values[$];
   bit                        seek_greater_sel;
   int                        fault_count;
   int                        beats_seen;
   int                        tx_gap;
   int                        rx_stall;
   bit                        tx_rush;
   bit                        rx_rush;

   nearest_smaller_greater_stack #(
      .STACK_DEPTH(STACK_N),
      .VALUE_WIDTH(VALUE_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s at beat %0d: got %h, expected %h", what, beats_seen, got, want);
      fault_count++;
   endtask

   function automatic nearest_result_type find_nearest(
      input logic signed [VALUE_W-1:0] value, input logic last);
      nearest_result_type res;
      res = '0;
      while (prior_values.size() > 0 &&
             !(seek_greater_sel ? (prior_values[$] > value) : (prior_values[$] < value)))
         void'(prior_values.pop_back());
      if (prior_values.size() > 0) begin
         res.nearest = prior_values[$];
         res.found = 1'b1;
      end
      if (prior_values.size() < STACK_N)
         prior_values.push_back(value);
      else
         res.overflow = 1'b1;
      if (last)
         prior_values.delete();
      res.last = last;
      return res;
   endfunction

   // stream driver
   always @(posedge clock) begin : tx_side
      array_elem_type elem;
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (req_tvalid && req_tready)
            nearest_due.push_back(find_nearest($signed(req_tdata), req_tlast));
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               req_tvalid <= 1'b0;
               tx_gap <= tx_gap - 1;
            end else if (elem_queue.size() > 0) begin
               elem = elem_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= elem.value;
               req_tlast <= elem.last;
               if ($urandom_range(0, 39) == 0)
                  tx_rush = !tx_rush;
               tx_gap <= tx_rush ? 0 : $urandom_range(0, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rx_side
      int                 hold;
      nearest_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall <= 0;
      end else begin
         hold = rx_stall;
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            if (nearest_due.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, '0);
            end else begin
               want = nearest_due.pop_front();
               if (rsp_tdata !== want.nearest)
                  report_mismatch("nearest_value", rsp_tdata, want.nearest);
               if (rsp_tuser[0] !== want.found)
                  report_mismatch("found", 32'(rsp_tuser[0]), 32'(want.found));
               if (rsp_tuser[1] !== want.overflow)
                  report_mismatch("stack_overflow", 32'(rsp_tuser[1]), 32'(want.overflow));
               if (rsp_tlast !== want.last)
                  report_mismatch("last_result", 32'(rsp_tlast), 32'(want.last));
            end
            if ($urandom_range(0, 39) == 0)
               rx_rush = !rx_rush;
            hold = rx_rush ? 0 : $urandom_range(0, 7);
            if (beats_seen == 60 || beats_seen == 1300)
               hold = LONG_HOLD;
         end
         rsp_tready <= (hold == 0);
         rx_stall <= (hold > 0) ? hold - 1 : 0;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == SEEK_GREATER_ADDR)
         seek_greater_sel = data[0];
   endtask

   task automatic csr_check(input bit want);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= SEEK_GREATER_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[0] !== want)
         report_mismatch("seek_greater readback", csr_prdata, {31'b0, want});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // upper bits are random, only bit 0 counts
   task automatic set_seek(input bit greater);
      logic [31:0] data;
      data = $urandom();
      data[0] = greater;
      csr_write(SEEK_GREATER_ADDR, data);
      csr_check(greater);
   endtask

   task automatic wait_drained();
      while (elem_queue.size() != 0 || req_tvalid || nearest_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void push_elem(input logic signed [VALUE_W-1:0] value, input logic last);
      array_elem_type elem;
      elem.value = value;
      elem.last = last;
      elem_queue.push_back(elem);
   endfunction

   function automatic void queue_random_array(input int len, input bit close);
      logic signed [VALUE_W-1:0] v;
      logic signed [VALUE_W-1:0] prev;
      int                        trend;
      prev = $urandom();
      trend = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         if (trend >= 2 && $urandom_range(0, 9) != 0) begin
            v = (trend == 2) ? prev + $urandom_range(1, 5000) : prev - $urandom_range(1, 5000);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: v = $signed($urandom_range(0, 16)) - 8;
               4, 5, 6:    v = $urandom();
               7: begin
                  case ($urandom_range(0, 3))
                     0:       v = VAL_MIN;
                     1:       v = VAL_MAX;
                     2:       v = 0;
                     default: v = -1;
                  endcase
               end
               default:    v = prev + $signed($urandom_range(0, 6)) - 3;
            endcase
         end
         push_elem(v, close && i == len - 1);
         prev = v;
      end
   endfunction

   initial begin : stimulus
      longint base;
      longint step;
      int     total;
      int     len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // smaller mode: empty stack, extremes, equal values, end of array
      set_seek(1'b0);
      push_elem(5, 1'b0);
      push_elem(VAL_MIN, 1'b0);
      push_elem(VAL_MAX, 1'b0);
      push_elem(VAL_MAX, 1'b0);
      push_elem(0, 1'b0);
      push_elem(-1, 1'b0);
      push_elem(-1, 1'b1);
      push_elem(7, 1'b1);
      wait_drained();

      // greater mode, spare address must not disturb the setting
      set_seek(1'b1);
      csr_write(SPARE_ADDR, 32'h0);
      csr_check(1'b1);
      push_elem(VAL_MIN, 1'b0);
      push_elem(VAL_MAX, 1'b0);
      push_elem(VAL_MAX, 1'b0);
      push_elem(0, 1'b0);
      push_elem(0, 1'b0);
      push_elem(-1, 1'b0);
      push_elem(VAL_MIN, 1'b0);
      push_elem(VAL_MIN, 1'b1);
      push_elem(3, 1'b1);
      wait_drained();

      // rising run past the stack depth, then a deep pop and a full clear
      set_seek(1'b0);
      base = -64'sd2147483648 + $urandom_range(0, 1000);
      step = $urandom_range(1, 2000000);
      for (int i = 0; i < STACK_N + 4; i++)
         push_elem(32'(base + longint'(i) * step), 1'b0);
      push_elem(32'(base + 500 * step), 1'b0);
      push_elem(VAL_MIN, 1'b1);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         set_seek(p == 0 ? 1'b1 : p == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
         total = 0;
         while (total < 130) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
            queue_random_array(len, total + len < 130 || $urandom_range(0, 1) == 1);
            total += len;
            if ($urandom_range(0, 7) == 0)
               wait_drained();
         end
         wait_drained();
      end

      if (fault_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/core/nsgs_pkg.sv
rtl/core/nsgs_ctrl.sv
rtl/core/nsgs_dpath.sv
rtl/core/nearest_smaller_greater_stack.sv
tb/tb.sv
